@@ rtl/ppc_pkg.sv @@
// Shared types, protocol constants and class codes of the packet classifier.
package ppc_pkg;

	localparam int PATTERN_BYTES_DEF = 4;

	localparam logic [31:0] MATCH_PATTERN_RESET = 32'h4854_5450;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam int ETH_HDR_BYTES = 14;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_IGMP = 8'd2;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_OSPF = 8'd89;

	localparam logic [15:0] PORT_SMTP = 16'd25;
	localparam logic [15:0] PORT_HTTP = 16'd80;
	localparam logic [15:0] PORT_DNS = 16'd53;
	localparam logic [15:0] PORT_SSDP = 16'd1900;

	typedef enum logic [3:0] {
		CLS_NON_IP = 4'd0,
		CLS_OTHER_IP = 4'd1,
		CLS_ICMP = 4'd2,
		CLS_IGMP = 4'd3,
		CLS_OSPF = 4'd4,
		CLS_TCP = 4'd5,
		CLS_SMTP = 4'd6,
		CLS_HTTP = 4'd7,
		CLS_UDP = 4'd8,
		CLS_DNS = 4'd9,
		CLS_SSDP = 4'd10
	} ppc_class_t;

	// Everything kept about one frame; also the hand-off from capture to classify.
	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [15:0] ether_kind;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [31:0] ports;
		logic [3:0]  tcp_offset;
		logic [7:0]  tcp_flags;
		logic [15:0] frame_length;
		logic        pattern_seen;
		logic [15:0] match_start;
	} ppc_frame_t;

	typedef struct packed {
		ppc_class_t  packet_class;
		logic [15:0] ether_kind;
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [7:0]  ip_proto;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  tcp_flag_bits;
		logic [15:0] frame_length;
	} ppc_result_t;

endpackage

@@ rtl/ppc_capture.sv @@
// Per-frame header field capture and payload marker search.
module ppc_capture
	import ppc_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       byte_value,
	input  logic             last_byte,
	input  logic [31:0]      match_pattern,
	output ppc_frame_t       frame_next
);

	localparam int WIN_W = 8 * PATTERN_BYTES;
	localparam int FILL_W = $clog2(PATTERN_BYTES + 1);

	ppc_frame_t         frame_q;
	logic [WIN_W-1:0]   window_q;
	logic [FILL_W-1:0]  fill_q;

	logic [WIN_W+7:0]   window_wide;
	logic [WIN_W-1:0]   window_next;
	logic [FILL_W-1:0]  fill_next;
	logic [63:0]        pattern_ext;
	logic [15:0]        p;
	logic [3:0]         ihl_next;
	logic [6:0]         l4_start;
	logic [15:0]        l4_rel;
	logic [2:0]         dmac_idx;
	logic [2:0]         smac_idx;
	logic [1:0]         sip_idx;
	logic [1:0]         dip_idx;
	logic [1:0]         port_idx;

	always_comb begin
		p = frame_q.frame_length;
		frame_next = frame_q;

		dmac_idx = 3'(3'd5 - p[2:0]);
		smac_idx = 3'(4'd11 - p[3:0]);
		sip_idx = 2'(5'd29 - p[4:0]);
		dip_idx = 2'(6'd33 - p[5:0]);

		if (p < 16'd6) begin
			frame_next.dest_mac[{dmac_idx, 3'b000} +: 8] = byte_value;
		end else if (p < 16'd12) begin
			frame_next.source_mac[{smac_idx, 3'b000} +: 8] = byte_value;
		end else if (p == 16'd12) begin
			frame_next.ether_kind[15:8] = byte_value;
		end else if (p == 16'd13) begin
			frame_next.ether_kind[7:0] = byte_value;
		end

		ihl_next = (p == 16'(ETH_HDR_BYTES)) ? byte_value[3:0] : frame_q.ihl;
		frame_next.ihl = ihl_next;
		if (p == 16'd23) begin
			frame_next.proto = byte_value;
		end
		if (p >= 16'd26 && p < 16'd30) begin
			frame_next.source_ip[{sip_idx, 3'b000} +: 8] = byte_value;
		end
		if (p >= 16'd30 && p < 16'd34) begin
			frame_next.dest_ip[{dip_idx, 3'b000} +: 8] = byte_value;
		end

		// The L4 header position follows the header length seen on this very byte.
		l4_start = 7'(ETH_HDR_BYTES) + 7'({ihl_next, 2'b00});
		l4_rel = p - {9'b0, l4_start};
		port_idx = 2'(2'd3 - l4_rel[1:0]);
		if (p >= {9'b0, l4_start} && l4_rel < 16'd4) begin
			frame_next.ports[{port_idx, 3'b000} +: 8] = byte_value;
		end
		if (p == {9'b0, l4_start} + 16'd12) begin
			frame_next.tcp_offset = byte_value[7:4];
		end
		if (p == {9'b0, l4_start} + 16'd13) begin
			frame_next.tcp_flags = byte_value;
		end

		// Marker search over the most recent bytes.
		window_wide = {window_q, byte_value};
		window_next = window_wide[WIN_W-1:0];
		pattern_ext = {32'b0, match_pattern};
		fill_next = (fill_q < FILL_W'(PATTERN_BYTES)) ? FILL_W'(fill_q + 1'b1) : fill_q;
		if (fill_next >= FILL_W'(PATTERN_BYTES) && window_next == pattern_ext[WIN_W-1:0]) begin
			frame_next.pattern_seen = 1'b1;
			frame_next.match_start = p - 16'(PATTERN_BYTES - 1);
		end

		if (p != 16'hFFFF) begin
			frame_next.frame_length = p + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			window_q <= '0;
			fill_q <= '0;
		end else if (fire) begin
			if (last_byte) begin
				frame_q <= '0;
				window_q <= '0;
				fill_q <= '0;
			end else begin
				frame_q <= frame_next;
				window_q <= window_next;
				fill_q <= fill_next;
			end
		end
	end

endmodule

@@ rtl/ppc_classify.sv @@
// Class decision and field masking for one completed frame.
module ppc_classify
	import ppc_pkg::*;
(
	input  ppc_frame_t  frame,
	output ppc_result_t result
);

	logic        is_ip;
	logic        is_tcp;
	logic        is_udp;
	logic [15:0] sp;
	logic [15:0] dp;
	logic [7:0]  payload_start;
	logic        match_ok;
	ppc_class_t  cls;

	always_comb begin
		is_ip = frame.ether_kind == ETHERTYPE_IPV4;
		is_tcp = is_ip && frame.proto == PROTO_TCP;
		is_udp = is_ip && frame.proto == PROTO_UDP;
		sp = frame.ports[31:16];
		dp = frame.ports[15:0];
		payload_start = 8'(ETH_HDR_BYTES) + 8'({frame.ihl, 2'b00})
			+ 8'({frame.tcp_offset, 2'b00});
		match_ok = frame.pattern_seen && frame.match_start >= {8'b0, payload_start};

		cls = CLS_NON_IP;
		if (is_ip) begin
			case (frame.proto)
				PROTO_ICMP: cls = CLS_ICMP;
				PROTO_IGMP: cls = CLS_IGMP;
				PROTO_OSPF: cls = CLS_OSPF;
				PROTO_TCP: begin
					if (sp == PORT_SMTP || dp == PORT_SMTP) begin
						cls = CLS_SMTP;
					end else if ((sp == PORT_HTTP || dp == PORT_HTTP) && match_ok) begin
						cls = CLS_HTTP;
					end else begin
						cls = CLS_TCP;
					end
				end
				PROTO_UDP: begin
					if (sp == PORT_DNS || dp == PORT_DNS) begin
						cls = CLS_DNS;
					end else if (sp == PORT_SSDP || dp == PORT_SSDP) begin
						cls = CLS_SSDP;
					end else begin
						cls = CLS_UDP;
					end
				end
				default: cls = CLS_OTHER_IP;
			endcase
		end

		result.packet_class = cls;
		result.ether_kind = frame.ether_kind;
		result.source_mac = frame.source_mac;
		result.dest_mac = frame.dest_mac;
		result.source_ip = is_ip ? frame.source_ip : 32'b0;
		result.dest_ip = is_ip ? frame.dest_ip : 32'b0;
		result.ip_proto = is_ip ? frame.proto : 8'b0;
		result.source_port = (is_tcp || is_udp) ? sp : 16'b0;
		result.dest_port = (is_tcp || is_udp) ? dp : 16'b0;
		result.tcp_flag_bits = is_tcp ? frame.tcp_flags : 8'b0;
		result.frame_length = frame.frame_length;
	end

endmodule

@@ rtl/packet_protocol_classifier_core.sv @@
// Top level of the Ethernet / IPv4 / L4 packet classifier.
//
// The core takes one captured frame as a stream of byte beats, starting at the Ethernet
// destination address, one beat per clock when the input is kept full and in_ready stays
// high; the last beat of a frame is flagged with last_byte. It keeps the MAC addresses,
// EtherType, IPv4 header length, protocol and addresses, the L4 ports, the TCP data offset
// and flags, and searches the TCP payload for a PATTERN_BYTES-long marker held in the
// match_pattern register (first marker byte in the high bits, reset value "HTTP"). For every
// frame it delivers exactly one result beat: the class (non-IP, other IP, ICMP, IGMP, OSPF,
// TCP, SMTP, HTTP, UDP, DNS or SSDP) together with the header fields; header bytes that
// never arrived read as zero and the length saturates at 65535. Each byte passes through the
// input register into the capture logic, and the result of a frame reaches the output through
// the hand-off and output registers. The three registers (input, frame hand-off, output) each
// have their own stall condition, so a waiting result holds up only the last byte of the
// next frame. The pattern register may be written only while no frame is in flight.

module packet_protocol_classifier_core
	import ppc_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  packet_class,
	output logic [15:0] ether_kind,
	output logic [47:0] source_mac,
	output logic [47:0] dest_mac,
	output logic [31:0] source_ip,
	output logic [31:0] dest_ip,
	output logic [7:0]  ip_proto,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [7:0]  tcp_flag_bits,
	output logic [15:0] frame_length
);

	logic [31:0] match_pattern_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	logic        valid_s2;
	ppc_frame_t  frame_s2;

	logic        out_valid_q;
	ppc_result_t result_q;

	ppc_frame_t  frame_next;
	ppc_result_t result_next;

	logic        out_free;
	logic        s2_free;
	logic        s1_go;

	// The pattern register accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pattern_q <= MATCH_PATTERN_RESET;
		end else if (cfg_valid) begin
			match_pattern_q <= cfg_data;
		end
	end

	// Stall chain. Only a last byte needs room in the hand-off register, so ordinary bytes
	// keep flowing while a finished frame waits at the output.
	assign out_free = !out_valid_q || out_ready;
	assign s2_free = !valid_s2 || out_free;
	assign s1_go = valid_s1 && (!last_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	ppc_capture #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (s1_go),
		.byte_value    (byte_s1),
		.last_byte     (last_s1),
		.match_pattern (match_pattern_q),
		.frame_next    (frame_next)
	);

	// Hand-off register: the completed frame, including the effect of its last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_go && last_s1) begin
			frame_s2 <= frame_next;
		end
	end

	ppc_classify u_classify (
		.frame  (frame_s2),
		.result (result_next)
	);

	// Output register holds the result beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			result_q <= result_next;
		end
	end

	assign out_valid = out_valid_q;
	assign packet_class = result_q.packet_class;
	assign ether_kind = result_q.ether_kind;
	assign source_mac = result_q.source_mac;
	assign dest_mac = result_q.dest_mac;
	assign source_ip = result_q.source_ip;
	assign dest_ip = result_q.dest_ip;
	assign ip_proto = result_q.ip_proto;
	assign source_port = result_q.source_port;
	assign dest_port = result_q.dest_port;
	assign tcp_flag_bits = result_q.tcp_flag_bits;
	assign frame_length = result_q.frame_length;

endmodule
